/* sv/fuqs_pkg.sv */
`timescale 1ns / 1ps

package fuqs_pkg;

   localparam int NUM_CORNERS = 4;

   typedef logic [$clog2(NUM_CORNERS)-1:0] corner_idx_type;

   localparam corner_idx_type QUAD_LAST = corner_idx_type'(NUM_CORNERS - 1);
   localparam corner_idx_type TRI_LAST  = corner_idx_type'(NUM_CORNERS - 2);

   function automatic corner_idx_type last_corner(input logic is_quad);
      return is_quad ? QUAD_LAST : TRI_LAST;
   endfunction

   function automatic corner_idx_type prev_corner(input corner_idx_type idx,
                                                  input logic is_quad);
      return (idx == '0) ? last_corner(is_quad) : idx - corner_idx_type'(1);
   endfunction

   function automatic corner_idx_type next_corner(input corner_idx_type idx,
                                                  input logic is_quad);
      return (idx == last_corner(is_quad)) ? '0 : idx + corner_idx_type'(1);
   endfunction

endpackage

/* sv/fuqs_req_if.sv */
`timescale 1ns / 1ps

interface fuqs_req_if #(
   parameter int UV_WIDTH = 16
);
   logic                       valid;
   logic                       ready;
   logic signed [UV_WIDTH-1:0] corner0_u;
   logic signed [UV_WIDTH-1:0] corner0_v;
   logic signed [UV_WIDTH-1:0] corner1_u;
   logic signed [UV_WIDTH-1:0] corner1_v;
   logic signed [UV_WIDTH-1:0] corner2_u;
   logic signed [UV_WIDTH-1:0] corner2_v;
   logic signed [UV_WIDTH-1:0] corner3_u;
   logic signed [UV_WIDTH-1:0] corner3_v;
   logic                       is_quad;
   logic                       final_face;

   modport source (
      output valid, corner0_u, corner0_v, corner1_u, corner1_v,
             corner2_u, corner2_v, corner3_u, corner3_v, is_quad, final_face,
      input  ready
   );

   modport sink (
      input  valid, corner0_u, corner0_v, corner1_u, corner1_v,
             corner2_u, corner2_v, corner3_u, corner3_v, is_quad, final_face,
      output ready
   );
endinterface

/* sv/fuqs_rsp_if.sv */
`timescale 1ns / 1ps

interface fuqs_rsp_if #(
   parameter int UV_WIDTH = 16
);
   logic                       valid;
   logic                       ready;
   logic signed [UV_WIDTH-1:0] sub_uv0_u;
   logic signed [UV_WIDTH-1:0] sub_uv0_v;
   logic signed [UV_WIDTH-1:0] sub_uv1_u;
   logic signed [UV_WIDTH-1:0] sub_uv1_v;
   logic signed [UV_WIDTH-1:0] sub_uv2_u;
   logic signed [UV_WIDTH-1:0] sub_uv2_v;
   logic signed [UV_WIDTH-1:0] sub_uv3_u;
   logic signed [UV_WIDTH-1:0] sub_uv3_v;
   logic                       last_of_face;
   logic                       ends_mesh;

   modport source (
      output valid, sub_uv0_u, sub_uv0_v, sub_uv1_u, sub_uv1_v,
             sub_uv2_u, sub_uv2_v, sub_uv3_u, sub_uv3_v, last_of_face, ends_mesh,
      input  ready
   );

   modport sink (
      input  valid, sub_uv0_u, sub_uv0_v, sub_uv1_u, sub_uv1_v,
             sub_uv2_u, sub_uv2_v, sub_uv3_u, sub_uv3_v, last_of_face, ends_mesh,
      output ready
   );
endinterface

/* sv/fuqs_centroid.sv */
`timescale 1ns / 1ps

module fuqs_centroid #(
   parameter int UV_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   fuqs_req_if.sink                   req_if,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic signed [UV_WIDTH-1:0] out_cu [fuqs_pkg::NUM_CORNERS],
   output logic signed [UV_WIDTH-1:0] out_cv [fuqs_pkg::NUM_CORNERS],
   output logic                       out_quad,
   output logic                       out_final,
   output logic signed [UV_WIDTH-1:0] out_mu,
   output logic signed [UV_WIDTH-1:0] out_mv
);

   localparam int SW = UV_WIDTH + 2;
   localparam int K  = UV_WIDTH + 3;
   localparam int PW = SW + K;
   // offset that makes sum + 1 positive before the divide by three
   localparam logic [SW-1:0] BIAS = SW'((64'd3 << (UV_WIDTH - 1)) + 64'd1);
   localparam logic [K-1:0] RECIP = K'(((64'd1 << K) / 64'd3) + 64'd1);
   localparam logic [UV_WIDTH-1:0] OFFSET = UV_WIDTH'(64'd1 << (UV_WIDTH - 1));

   logic signed [UV_WIDTH-1:0] req_cu [fuqs_pkg::NUM_CORNERS];
   logic signed [UV_WIDTH-1:0] req_cv [fuqs_pkg::NUM_CORNERS];

   logic                       s1_valid_ff, s1_valid_in;
   logic signed [UV_WIDTH-1:0] s1_cu_ff [fuqs_pkg::NUM_CORNERS];
   logic signed [UV_WIDTH-1:0] s1_cv_ff [fuqs_pkg::NUM_CORNERS];
   logic                       s1_quad_ff;
   logic                       s1_final_ff;
   logic                       s1_ready;

   logic                       s2_valid_ff, s2_valid_in;
   logic signed [UV_WIDTH-1:0] s2_cu_ff [fuqs_pkg::NUM_CORNERS];
   logic signed [UV_WIDTH-1:0] s2_cv_ff [fuqs_pkg::NUM_CORNERS];
   logic                       s2_quad_ff;
   logic                       s2_final_ff;
   logic signed [UV_WIDTH-1:0] s2_qu_ff, s2_qu_in;
   logic signed [UV_WIDTH-1:0] s2_qv_ff, s2_qv_in;
   logic [SW-1:0]              s2_mu_ff, s2_mu_in;
   logic [SW-1:0]              s2_mv_ff, s2_mv_in;
   logic                       s2_ready;

   logic signed [SW-1:0]       sum_u, sum_v;
   logic [PW-1:0]              prod_u, prod_v;
   logic [UV_WIDTH-1:0]        tri_u, tri_v;

   assign req_cu[0] = req_if.corner0_u;
   assign req_cv[0] = req_if.corner0_v;
   assign req_cu[1] = req_if.corner1_u;
   assign req_cv[1] = req_if.corner1_v;
   assign req_cu[2] = req_if.corner2_u;
   assign req_cv[2] = req_if.corner2_v;
   assign req_cu[3] = req_if.corner3_u;
   assign req_cv[3] = req_if.corner3_v;

   assign s2_ready     = !s2_valid_ff || out_ready;
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_if.ready = s1_ready;

   assign s1_valid_in = s1_ready ? req_if.valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      sum_u = SW'(s1_cu_ff[0]) + SW'(s1_cu_ff[1]) + SW'(s1_cu_ff[2]);
      sum_v = SW'(s1_cv_ff[0]) + SW'(s1_cv_ff[1]) + SW'(s1_cv_ff[2]);
      if (s1_quad_ff) begin
         sum_u = sum_u + SW'(s1_cu_ff[3]);
         sum_v = sum_v + SW'(s1_cv_ff[3]);
      end
      s2_qu_in = UV_WIDTH'(sum_u >>> 2);
      s2_qv_in = UV_WIDTH'(sum_v >>> 2);
      s2_mu_in = $unsigned(sum_u) + BIAS;
      s2_mv_in = $unsigned(sum_v) + BIAS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_cu_ff    <= req_cu;
         s1_cv_ff    <= req_cv;
         s1_quad_ff  <= req_if.is_quad;
         s1_final_ff <= req_if.final_face;
      end
      if (s2_ready) begin
         s2_cu_ff    <= s1_cu_ff;
         s2_cv_ff    <= s1_cv_ff;
         s2_quad_ff  <= s1_quad_ff;
         s2_final_ff <= s1_final_ff;
         s2_qu_ff    <= s2_qu_in;
         s2_qv_ff    <= s2_qv_in;
         s2_mu_ff    <= s2_mu_in;
         s2_mv_ff    <= s2_mv_in;
      end
   end

   // divide by three through the reciprocal, then remove the offset
   assign prod_u = PW'(s2_mu_ff) * PW'(RECIP);
   assign prod_v = PW'(s2_mv_ff) * PW'(RECIP);
   assign tri_u  = UV_WIDTH'(prod_u >> K) - OFFSET;
   assign tri_v  = UV_WIDTH'(prod_v >> K) - OFFSET;

   assign out_valid = s2_valid_ff;
   assign out_cu    = s2_cu_ff;
   assign out_cv    = s2_cv_ff;
   assign out_quad  = s2_quad_ff;
   assign out_final = s2_final_ff;
   assign out_mu    = s2_quad_ff ? s2_qu_ff : $signed(tri_u);
   assign out_mv    = s2_quad_ff ? s2_qv_ff : $signed(tri_v);

endmodule

/* sv/fuqs_emit.sv */
`timescale 1ns / 1ps

module fuqs_emit #(
   parameter int UV_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [UV_WIDTH-1:0] in_cu [fuqs_pkg::NUM_CORNERS],
   input  logic signed [UV_WIDTH-1:0] in_cv [fuqs_pkg::NUM_CORNERS],
   input  logic                       in_quad,
   input  logic                       in_final,
   input  logic signed [UV_WIDTH-1:0] in_mu,
   input  logic signed [UV_WIDTH-1:0] in_mv,
   fuqs_rsp_if.source                 rsp_if
);

   function automatic logic signed [UV_WIDTH-1:0] midpoint(
      input logic signed [UV_WIDTH-1:0] a,
      input logic signed [UV_WIDTH-1:0] b
   );
      logic signed [UV_WIDTH:0] s;
      s = (UV_WIDTH+1)'(a) + (UV_WIDTH+1)'(b);
      return UV_WIDTH'(s >>> 1);
   endfunction

   logic                       hold_valid_ff, hold_valid_in;
   fuqs_pkg::corner_idx_type   idx_ff, idx_in;
   logic signed [UV_WIDTH-1:0] hold_cu_ff [fuqs_pkg::NUM_CORNERS];
   logic signed [UV_WIDTH-1:0] hold_cv_ff [fuqs_pkg::NUM_CORNERS];
   logic                       hold_quad_ff;
   logic                       hold_final_ff;
   logic signed [UV_WIDTH-1:0] hold_mu_ff;
   logic signed [UV_WIDTH-1:0] hold_mv_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [UV_WIDTH-1:0] uv0_u_ff, uv0_v_ff, uv1_u_ff, uv1_v_ff;
   logic signed [UV_WIDTH-1:0] uv2_u_ff, uv2_v_ff, uv3_u_ff, uv3_v_ff;
   logic                       last_ff, ends_ff;

   fuqs_pkg::corner_idx_type   prev_idx, next_idx;
   logic                       step, last, in_xfer;

   assign prev_idx = fuqs_pkg::prev_corner(idx_ff, hold_quad_ff);
   assign next_idx = fuqs_pkg::next_corner(idx_ff, hold_quad_ff);
   assign last     = idx_ff == fuqs_pkg::last_corner(hold_quad_ff);
   assign step     = hold_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign in_ready = !hold_valid_ff || (step && last);
   assign in_xfer  = in_valid && in_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      idx_in        = idx_ff;
      if (in_xfer) begin
         hold_valid_in = 1'b1;
         idx_in        = '0;
      end else if (step) begin
         hold_valid_in = !last;
         idx_in        = idx_ff + fuqs_pkg::corner_idx_type'(1);
      end
      rsp_valid_in = step ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_xfer) begin
         hold_cu_ff    <= in_cu;
         hold_cv_ff    <= in_cv;
         hold_quad_ff  <= in_quad;
         hold_final_ff <= in_final;
         hold_mu_ff    <= in_mu;
         hold_mv_ff    <= in_mv;
      end
      if (step) begin
         uv0_u_ff <= midpoint(hold_cu_ff[idx_ff], hold_cu_ff[prev_idx]);
         uv0_v_ff <= midpoint(hold_cv_ff[idx_ff], hold_cv_ff[prev_idx]);
         uv1_u_ff <= hold_cu_ff[idx_ff];
         uv1_v_ff <= hold_cv_ff[idx_ff];
         uv2_u_ff <= midpoint(hold_cu_ff[idx_ff], hold_cu_ff[next_idx]);
         uv2_v_ff <= midpoint(hold_cv_ff[idx_ff], hold_cv_ff[next_idx]);
         uv3_u_ff <= hold_mu_ff;
         uv3_v_ff <= hold_mv_ff;
         last_ff  <= last;
         ends_ff  <= last && hold_final_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sub_uv0_u    = uv0_u_ff;
   assign rsp_if.sub_uv0_v    = uv0_v_ff;
   assign rsp_if.sub_uv1_u    = uv1_u_ff;
   assign rsp_if.sub_uv1_v    = uv1_v_ff;
   assign rsp_if.sub_uv2_u    = uv2_u_ff;
   assign rsp_if.sub_uv2_v    = uv2_v_ff;
   assign rsp_if.sub_uv3_u    = uv3_u_ff;
   assign rsp_if.sub_uv3_v    = uv3_v_ff;
   assign rsp_if.last_of_face = last_ff;
   assign rsp_if.ends_mesh    = ends_ff;

endmodule

/* sv/face_uv_quad_split_unit.sv */
// a face passes the centroid stages, then the hold registers, then the result register
// throughput: one subface per cycle while the result is not stalled; a triangle
//   yields three and a quad four, from the single builder of the result register
// a new face is taken while earlier faces are still in the centroid stages
// reset is synchronous, active high, and clears every valid flag
`timescale 1ns / 1ps

module face_uv_quad_split_unit #(
   parameter int UV_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   fuqs_req_if.sink    req_if,
   fuqs_rsp_if.source  rsp_if
);

   logic                       cent_valid;
   logic                       cent_ready;
   logic signed [UV_WIDTH-1:0] cent_cu [fuqs_pkg::NUM_CORNERS];
   logic signed [UV_WIDTH-1:0] cent_cv [fuqs_pkg::NUM_CORNERS];
   logic                       cent_quad;
   logic                       cent_final;
   logic signed [UV_WIDTH-1:0] cent_mu;
   logic signed [UV_WIDTH-1:0] cent_mv;

   fuqs_centroid #(
      .UV_WIDTH (UV_WIDTH)
   ) u_centroid (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .out_valid (cent_valid),
      .out_ready (cent_ready),
      .out_cu    (cent_cu),
      .out_cv    (cent_cv),
      .out_quad  (cent_quad),
      .out_final (cent_final),
      .out_mu    (cent_mu),
      .out_mv    (cent_mv)
   );

   fuqs_emit #(
      .UV_WIDTH (UV_WIDTH)
   ) u_emit (
      .clock    (clock),
      .reset    (reset),
      .in_valid (cent_valid),
      .in_ready (cent_ready),
      .in_cu    (cent_cu),
      .in_cv    (cent_cv),
      .in_quad  (cent_quad),
      .in_final (cent_final),
      .in_mu    (cent_mu),
      .in_mv    (cent_mv),
      .rsp_if   (rsp_if)
   );

endmodule

/* sv/fuqs_checker.sv */
`timescale 1ns / 1ps

module fuqs_checker #(
   parameter int UV_WIDTH = 16
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [UV_WIDTH-1:0] rsp_sub_uv3_u,
   input logic                       rsp_last_of_face,
   input logic                       rsp_ends_mesh
);

   logic [1:0] sub_cnt_ff, sub_cnt_in;
   logic       rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      sub_cnt_in = sub_cnt_ff;
      if (rsp_xfer) begin
         sub_cnt_in = rsp_last_of_face ? 2'd0 : sub_cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_cnt_ff <= 2'd0;
      end else begin
         sub_cnt_ff <= sub_cnt_in;
      end
   end

   a_reset_clears_valid: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sub_uv3_u)
                                  && $stable(rsp_last_of_face))
      else $error("stalled result changed");

   a_ends_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ends_mesh |-> rsp_last_of_face)
      else $error("mesh end not on last subface");

   a_max_four: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && sub_cnt_ff == 2'd3 |-> rsp_last_of_face)
      else $error("more than four subfaces in a face");

   a_min_three: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_last_of_face |-> sub_cnt_ff == 2'd2 || sub_cnt_ff == 2'd3)
      else $error("face ended with fewer than three subfaces");

endmodule

bind face_uv_quad_split_unit fuqs_checker #(
   .UV_WIDTH (UV_WIDTH)
) u_fuqs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_sub_uv3_u    (rsp_if.sub_uv3_u),
   .rsp_last_of_face (rsp_if.last_of_face),
   .rsp_ends_mesh    (rsp_if.ends_mesh)
);
